// ===== src/pint_pkg.sv =====
package pint_pkg;

    // Angle reduction works on Q.30 radians, wide enough for a Q8.24 angle times 64
    // plus the offset that makes negative angles positive.
    localparam int RED_W = 41;
    localparam int RED_SHIFTS = 5;
    localparam logic signed [RED_W-1:0] Q30_PI = 41'sd3373259426;
    localparam logic signed [RED_W-1:0] Q30_TWO_PI = 41'sd6746518852;
    localparam logic signed [RED_W-1:0] Q30_HALF_PI = 41'sd1686629713;
    localparam logic signed [RED_W-1:0] RED_OFFSET = Q30_TWO_PI <<< RED_SHIFTS;

    // CORDIC datapath, Q6.30.
    localparam int CORDIC_W = 36;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 36'sh026DD3B6A;
    localparam int SINE_W = 33;
    localparam int ATAN_IDX_W = 6;

    function automatic logic [31:0] f_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h3243F6A8;
            6'd1:  v = 32'h1DAC6705;
            6'd2:  v = 32'h0FADBAFC;
            6'd3:  v = 32'h07F56EA6;
            6'd4:  v = 32'h03FEAB76;
            6'd5:  v = 32'h01FFD55B;
            6'd6:  v = 32'h00FFFAAA;
            6'd7:  v = 32'h007FFF55;
            6'd8:  v = 32'h003FFFEA;
            6'd9:  v = 32'h001FFFFD;
            6'd10: v = 32'h000FFFFF;
            6'd11: v = 32'h0007FFFF;
            6'd12: v = 32'h0003FFFF;
            6'd13: v = 32'h0001FFFF;
            6'd14: v = 32'h0000FFFF;
            6'd15: v = 32'h00007FFF;
            6'd16: v = 32'h00003FFF;
            6'd17: v = 32'h00001FFF;
            6'd18: v = 32'h00000FFF;
            6'd19: v = 32'h000007FF;
            6'd20: v = 32'h000003FF;
            6'd21: v = 32'h000001FF;
            6'd22: v = 32'h000000FF;
            6'd23: v = 32'h0000007F;
            6'd24: v = 32'h0000003F;
            6'd25: v = 32'h0000001F;
            6'd26: v = 32'h0000000F;
            6'd27: v = 32'h00000008;
            6'd28: v = 32'h00000004;
            6'd29: v = 32'h00000002;
            6'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/pendulum_integrator.sv =====
// Pendulum integrator: each input item advances a point-mass pendulum by one time step.
// Input channel: i_in_valid / o_in_ready carry one item with the i_restart bit. A set bit
// reloads angle and speed from the start registers and clears the step counter and the
// saturation flag before the step is taken.
// Output channel: o_out_valid / i_out_ready carry angle, speed, acceleration and the
// sticky saturation flag, once every decimation steps (decimation zero acts as one).
// Configuration goes through the APB port: gain at 0x00, step size at 0x04, start angle
// at 0x08, start speed at 0x0C, decimation at 0x10. Write them only while the block is idle.
// Each item runs through the iterative sine unit (six reduction passes, one fold,
// CORDIC_STEPS rotations), five products through the one shared 33x33 multiplier and
// the update; o_out_valid is set from the emit state that follows when a result is due.
// The next item is accepted only once the block is back in its idle state.
// A finished result sits in the output register; the block takes the next item while it
// waits. If the next result is ready before the receiver took the previous one, the
// block holds in its emit state until the output register frees.
// Reset clears the control and pendulum state and loads the register defaults: unit gain, a step of about
// one millisecond, zero start angle and speed, and a decimation of ten.
module pendulum_integrator
    import pint_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_angle_out,
    output logic [31:0] o_speed_out,
    output logic [31:0] o_accel_out,
    output logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW_EFF = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam logic signed [67:0] SAT_HI = (68'sd1 <<< (DW_EFF - 1)) - 68'sd1;
    localparam logic signed [67:0] SAT_LO = -SAT_HI - 68'sd1;
    localparam logic signed [65:0] RND23 = 66'sd1 <<< 23;
    localparam logic signed [65:0] RND29 = 66'sd1 <<< 29;
    localparam logic signed [65:0] RND31 = 66'sd1 <<< 31;

    typedef enum logic [2:0] {
        REG_GAIN        = 3'd0,
        REG_STEP_SIZE   = 3'd1,
        REG_START_ANGLE = 3'd2,
        REG_START_SPEED = 3'd3,
        REG_DECIMATION  = 3'd4
    } t_reg_idx;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_WAIT  = 10'b0000000100,
        S_MG    = 10'b0000001000,
        S_MT    = 10'b0000010000,
        S_MV    = 10'b0000100000,
        S_MA    = 10'b0001000000,
        S_MD    = 10'b0010000000,
        S_UPD   = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    function automatic logic signed [DW_EFF-1:0] f_sat(input logic signed [67:0] v);
        logic signed [DW_EFF-1:0] r;
        if (v > SAT_HI) begin
            r = DW_EFF'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = DW_EFF'(SAT_LO);
        end else begin
            r = DW_EFF'(v);
        end
        return r;
    endfunction

    function automatic logic f_ovf(input logic signed [67:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    t_state r_state, n_state;

    logic [31:0]        r_gain, r_step;
    logic signed [31:0] r_start_angle, r_start_speed;
    logic [9:0]         r_dec;

    logic signed [DW_EFF-1:0] r_angle, r_speed, r_accel;
    logic [9:0]               r_cnt;
    logic                     r_sat;
    logic [31:0]              r_half;
    logic signed [65:0]       r_wide;
    logic signed [65:0]       r_prod;

    logic               r_out_valid;
    logic [31:0]        r_o_angle, r_o_speed, r_o_accel;
    logic               r_o_sat;

    logic                     w_cfg_wr;
    t_reg_idx                 w_idx;
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_cordic_done;
    logic signed [SINE_W-1:0] w_sine;
    logic signed [32:0]       w_ma, w_mb;
    logic signed [65:0]       w_acc;
    logic [64:0]              w_dt2;
    logic signed [65:0]       w_dv;
    logic signed [65:0]       w_ang;
    logic signed [67:0]       w_ang_x;
    logic signed [67:0]       w_spd;
    logic [9:0]               w_dec_eff;
    logic [9:0]               w_next;
    logic                     w_emit;

    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_idx      = t_reg_idx'(paddr[4:2]);
    assign pready     = 1'b1;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (w_idx)
            REG_GAIN:        prdata = r_gain;
            REG_STEP_SIZE:   prdata = r_step;
            REG_START_ANGLE: prdata = r_start_angle;
            REG_START_SPEED: prdata = r_start_speed;
            REG_DECIMATION:  prdata = {22'd0, r_dec};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= 32'd16777216;
            r_step        <= 32'd4294967;
            r_start_angle <= '0;
            r_start_speed <= '0;
            r_dec         <= 10'd10;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_GAIN:        r_gain <= pwdata;
                REG_STEP_SIZE:   r_step <= pwdata;
                REG_START_ANGLE: r_start_angle <= pwdata;
                REG_START_SPEED: r_start_speed <= pwdata;
                REG_DECIMATION:  r_dec <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    pint_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_W      (DW_EFF)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_angle (r_angle),
        .o_done  (w_cordic_done),
        .o_sine  (w_sine)
    );

    // Shared multiplier: each state picks the pair whose product the next state consumes.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MG: begin
                w_ma = signed'({1'b0, r_gain});
                w_mb = w_sine;
            end
            S_MT: begin
                w_ma = signed'({1'b0, r_step});
                w_mb = signed'({1'b0, r_step});
            end
            S_MV: begin
                w_ma = 33'(r_speed);
                w_mb = signed'({1'b0, r_step});
            end
            S_MA: begin
                w_ma = 33'(r_accel);
                w_mb = signed'({1'b0, r_half});
            end
            S_MD: begin
                w_ma = 33'(r_accel);
                w_mb = signed'({1'b0, r_step});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    assign w_acc     = (r_prod + RND29) >>> 30;
    assign w_dt2     = {1'b0, r_prod[63:0]} + 65'h1_0000_0000;
    assign w_dv      = (r_prod + RND31) >>> 32;
    assign w_ang     = (r_wide + RND23) >>> 24;
    assign w_ang_x   = 68'(w_ang);
    assign w_spd     = 68'(r_speed) + 68'(w_dv);
    assign w_dec_eff = (r_dec == 10'd0) ? 10'd1 : r_dec;
    assign w_next    = r_cnt + 10'd1;
    assign w_emit    = (w_next >= w_dec_eff) || (w_next == 10'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (w_cordic_done) n_state = S_MG;
            S_MG:    n_state = S_MT;
            S_MT:    n_state = S_MV;
            S_MV:    n_state = S_MA;
            S_MA:    n_state = S_MD;
            S_MD:    n_state = S_UPD;
            S_UPD:   n_state = w_emit ? S_EMIT : S_IDLE;
            S_EMIT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_angle <= '0;
            r_speed <= '0;
            r_accel <= '0;
            r_cnt   <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_restart) begin
                        r_angle <= f_sat(68'(r_start_angle));
                        r_speed <= f_sat(68'(r_start_speed));
                        r_accel <= '0;
                        r_cnt   <= '0;
                        r_sat   <= 1'b0;
                    end
                end
                S_MT: begin
                    // The acceleration saturates without touching the flag.
                    r_accel <= f_sat(-68'(w_acc));
                end
                S_UPD: begin
                    r_angle <= f_sat(w_ang_x);
                    r_speed <= f_sat(w_spd);
                    r_sat   <= r_sat || f_ovf(w_ang_x) || f_ovf(w_spd);
                    r_cnt   <= w_emit ? 10'd0 : w_next;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_sat <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // New angle in Q.48: old angle plus speed*dt plus accel*dt*dt/2.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MV) begin
            r_half <= w_dt2[64:33];
        end
        if (r_state == S_MA) begin
            r_wide <= (66'(r_angle) <<< 24) + (r_prod >>> 8);
        end else if (r_state == S_MD) begin
            r_wide <= r_wide + (r_prod >>> 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_o_angle <= 32'(r_angle);
            r_o_speed <= 32'(r_speed);
            r_o_accel <= 32'(r_accel);
            r_o_sat   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_angle_out = r_o_angle;
    assign o_speed_out = r_o_speed;
    assign o_accel_out = r_o_accel;
    assign o_saturated = r_o_sat;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block still ready the cycle after taking an item");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_done |-> (r_state == S_WAIT))
        else $error("sine finished while the sequencer was not waiting for it");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("emitted result did not reach the output register");

endmodule

// ===== src/pint_cordic.sv =====
module pint_cordic
    import pint_pkg::*;
#(
    parameter int CORDIC_STEPS = 24,
    parameter int ANGLE_W = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_done,
    output logic signed [SINE_W-1:0]  o_sine
);

    localparam int IT_W = $clog2(CORDIC_STEPS);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_RED  = 4'b0010,
        C_FOLD = 4'b0100,
        C_ROT  = 4'b1000
    } t_cstate;

    t_cstate r_state, n_state;
    logic signed [RED_W-1:0]    r_z, n_z;
    logic signed [CORDIC_W-1:0] r_x, n_x, r_y, n_y;
    logic [2:0]                 r_k, n_k;
    logic [IT_W-1:0]            r_it, n_it;
    logic                       r_done, n_done;

    logic signed [RED_W-1:0]    w_pre;
    logic signed [RED_W-1:0]    w_mod;
    logic signed [RED_W-1:0]    w_cen;
    logic signed [RED_W-1:0]    w_atan;
    logic signed [CORDIC_W-1:0] w_dx, w_dy;
    logic                       w_last;

    assign w_pre  = (RED_W'(i_angle) <<< 6) + Q30_PI;
    assign w_mod  = Q30_TWO_PI <<< r_k;
    assign w_cen  = r_z - Q30_PI;
    assign w_atan = RED_W'(f_atan(ATAN_IDX_W'(r_it)));
    assign w_dx   = r_y >>> r_it;
    assign w_dy   = r_x >>> r_it;
    assign w_last = (r_it == IT_W'(CORDIC_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_z     = r_z;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_it    = r_it;
        n_done  = 1'b0;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    // Shift negative angles up by a whole number of turns first.
                    n_z     = w_pre[RED_W-1] ? w_pre + RED_OFFSET : w_pre;
                    n_k     = 3'(RED_SHIFTS);
                    n_state = C_RED;
                end
            end
            C_RED: begin
                if (r_z >= w_mod) begin
                    n_z = r_z - w_mod;
                end
                n_k = r_k - 3'd1;
                if (r_k == 3'd0) begin
                    n_state = C_FOLD;
                end
            end
            C_FOLD: begin
                // Fold into [-pi/2, pi/2] using sin(x) = sin(+-pi - x).
                if (w_cen > Q30_HALF_PI) begin
                    n_z = Q30_PI - w_cen;
                end else if (w_cen < -Q30_HALF_PI) begin
                    n_z = -Q30_PI - w_cen;
                end else begin
                    n_z = w_cen;
                end
                n_x     = CORDIC_K;
                n_y     = '0;
                n_it    = '0;
                n_state = C_ROT;
            end
            C_ROT: begin
                if (!r_z[RED_W-1]) begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - w_atan;
                end else begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + w_atan;
                end
                n_it = r_it + IT_W'(1);
                if (w_last) begin
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_k     <= n_k;
            r_it    <= n_it;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z <= n_z;
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_done = r_done;
    assign o_sine = r_y[SINE_W-1:0];

endmodule
